// ===== hdl/mqtrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqtrs_pkg
// Shared codes and types of the multi-queue task ring set: operation codes,
// result status codes, port widths and the controller command bundle.
// ----------------------------------------------------------------------------
package mqtrs_pkg;

	localparam int OP_W     = 2;
	localparam int SEL_W    = 3;
	localparam int TASK_IO_W = 32;
	localparam int STATUS_W = 3;
	localparam int WAKE_W   = 8;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam op_t OP_PUSH     = 2'd0;
	localparam op_t OP_TRY_POP  = 2'd1;
	localparam op_t OP_POP_WAIT = 2'd2;
	localparam op_t OP_STOP_ALL = 2'd3;

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_FULL    = 3'd1;
	localparam status_t ST_EMPTY   = 3'd2;
	localparam status_t ST_STOPPED = 3'd3;
	localparam status_t ST_WAITING = 3'd4;
	localparam status_t ST_INVALID = 3'd5;

	typedef struct packed {
		logic load;
		logic exec;
	} mqtrs_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/mqtrs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqtrs_ctrl
// Controller of the queue set: takes one transaction, runs it through the
// datapath and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module mqtrs_ctrl
	import mqtrs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	output mqtrs_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.exec  = (state_q == S_EXEC);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mqtrs_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqtrs_datapath
// Datapath of the queue set: per-queue counters and flags, the slot memory
// holding every ring, and the result registers.
// ----------------------------------------------------------------------------
module mqtrs_datapath
	import mqtrs_pkg::*;
#(
	parameter int QUEUE_COUNT = 8,
	parameter int RING_DEPTH = 64,
	parameter int TASK_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mqtrs_cmd_t           cmd,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [SEL_W-1:0]     queue_sel,
	input  wire logic [TASK_IO_W-1:0] task_in,
	output logic [STATUS_W-1:0]       status,
	output logic [TASK_IO_W-1:0]      task_out,
	output logic [WAKE_W-1:0]         wake_mask
);

	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int CW = $clog2(2 * RING_DEPTH);
	localparam int SW = $clog2(RING_DEPTH);
	localparam int MEM_DEPTH = QUEUE_COUNT * RING_DEPTH;
	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int WAKE_Q = (QUEUE_COUNT < WAKE_W) ? QUEUE_COUNT : WAKE_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
	localparam logic [CW-1:0] CNT_LAST = CW'(2 * RING_DEPTH - 1);
	localparam logic [AW-1:0] DEPTH_A = AW'(RING_DEPTH);

	op_t                   op_q;
	logic [QW-1:0]         q_q;
	logic [TASK_WIDTH-1:0] task_q;

	logic [CW-1:0]   prod_q [QUEUE_COUNT];
	logic [CW-1:0]   cons_q [QUEUE_COUNT];
	logic [QUEUE_COUNT-1:0] wait_q;
	logic [QUEUE_COUNT-1:0] stop_q;

	logic [TASK_WIDTH-1:0] mem [MEM_DEPTH];
	logic [TASK_WIDTH-1:0] rd_q;

	status_t           status_q;
	logic [WAKE_W-1:0] wake_q;
	logic              pop_ok_q;

	logic [QW-1:0]   q_sel;
	logic [CW-1:0]   prod;
	logic [CW-1:0]   cons;
	logic [CW-1:0]   fill;
	logic [SW-1:0]   prod_slot;
	logic [SW-1:0]   cons_slot;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;
	logic            is_pop;
	logic            push_ok;
	logic            pop_ok;
	status_t         status_d;
	logic [WAKE_W-1:0] wake_d;

	// The queue index folds onto the queues present through a small table.
	always_comb begin
		q_sel = '0;
		for (int k = 0; k < (1 << SEL_W); k++) begin
			if (queue_sel == SEL_W'(k)) begin
				q_sel = QW'(k % QUEUE_COUNT);
			end
		end
	end

	always_comb begin
		prod = prod_q[q_q];
		cons = cons_q[q_q];
		fill = (prod >= cons) ? CW'(prod - cons) : CW'(prod + CW'(2 * RING_DEPTH) - cons);
		prod_slot = SW'((prod >= DEPTH_C) ? CW'(prod - DEPTH_C) : prod);
		cons_slot = SW'((cons >= DEPTH_C) ? CW'(cons - DEPTH_C) : cons);
		waddr = AW'(AW'(q_q) * DEPTH_A + AW'(prod_slot));
		raddr = AW'(AW'(q_q) * DEPTH_A + AW'(cons_slot));
		is_pop = (op_q == OP_TRY_POP) || (op_q == OP_POP_WAIT);
		push_ok = 1'b0;
		pop_ok = 1'b0;
		status_d = ST_OK;
		wake_d = '0;
		case (op_q)
			OP_PUSH: begin
				if (task_q == '0) begin
					status_d = ST_INVALID;
				end else if (fill == DEPTH_C) begin
					status_d = ST_FULL;
				end else begin
					push_ok = 1'b1;
					if (wait_q[q_q] && (int'(q_q) < WAKE_W)) begin
						wake_d[q_q] = 1'b1;
					end
				end
			end
			OP_TRY_POP, OP_POP_WAIT: begin
				if (stop_q[q_q]) begin
					status_d = ST_STOPPED;
				end else if (prod == cons) begin
					status_d = (op_q == OP_POP_WAIT) ? ST_WAITING : ST_EMPTY;
				end else begin
					pop_ok = 1'b1;
				end
			end
			default: begin
				for (int i = 0; i < WAKE_Q; i++) begin
					wake_d[i] = wait_q[i];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				prod_q[i] <= '0;
				cons_q[i] <= '0;
			end
			wait_q   <= '0;
			stop_q   <= '0;
			status_q <= ST_OK;
			wake_q   <= '0;
			pop_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			status_q <= status_d;
			wake_q   <= wake_d;
			pop_ok_q <= pop_ok;
			if (push_ok) begin
				prod_q[q_q] <= (prod == CNT_LAST) ? '0 : CW'(prod + 1'b1);
				wait_q[q_q] <= 1'b0;
			end
			if (pop_ok) begin
				cons_q[q_q] <= (cons == CNT_LAST) ? '0 : CW'(cons + 1'b1);
			end
			if (is_pop && (status_d == ST_WAITING)) begin
				wait_q[q_q] <= 1'b1;
			end
			if (op_q == OP_STOP_ALL) begin
				wait_q <= '0;
				stop_q <= '1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			q_q    <= q_sel;
			task_q <= TASK_WIDTH'(task_in);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && push_ok) begin
			mem[waddr] <= task_q;
		end
		if (cmd.exec && pop_ok) begin
			rd_q <= mem[raddr];
		end
	end

	assign status    = status_q;
	assign wake_mask = wake_q;
	assign task_out  = pop_ok_q ? TASK_IO_W'(rd_q) : '0;

endmodule
`default_nettype wire

// ===== hdl/multi_queue_task_ring_set.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_task_ring_set_core
// A set of ring FIFOs of task words with push, try-pop, pop-or-wait and
// stop-all operations, one result per operation.
//
// The input channel (in_valid, in_ready) carries one operation per
// transaction: op, queue_sel and task_in. The output channel (out_valid,
// out_ready) returns status, task_out and wake_mask for that operation.
// One operation is handled at a time. A transaction accepted at one edge is
// executed in the next cycle, and its result is offered from the cycle after
// that. The operand register feeds the execute cycle, in which the counters
// and the slot memory are read, and the single result register holds the
// result, which must be taken before the next transaction is accepted.
// While the receiver stalls, the result holds and in_ready stays low.
// Reset empties every queue and clears the waiter and stop flags; the slot
// memory is not cleared, as only written slots can ever be popped.
// ----------------------------------------------------------------------------
module multi_queue_task_ring_set_core
	import mqtrs_pkg::*;
#(
	parameter int QUEUE_COUNT = 8,
	parameter int RING_DEPTH = 64,
	parameter int TASK_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [SEL_W-1:0]     queue_sel,
	input  wire logic [TASK_IO_W-1:0] task_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [STATUS_W-1:0]       status,
	output logic [TASK_IO_W-1:0]      task_out,
	output logic [WAKE_W-1:0]         wake_mask
);

	mqtrs_cmd_t cmd;

	mqtrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	mqtrs_datapath #(
		.QUEUE_COUNT (QUEUE_COUNT),
		.RING_DEPTH  (RING_DEPTH),
		.TASK_WIDTH  (TASK_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (op),
		.queue_sel (queue_sel),
		.task_in   (task_in),
		.status    (status),
		.task_out  (task_out),
		.wake_mask (wake_mask)
	);

endmodule
`default_nettype wire
